### hdl/tstp_pkg.sv
// ---------------------------------------------------------------------------
// Text style tag parser package
// Shared character codes, alignment codes, types and the hex digit decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package tstp_pkg;

   // Character codes that the parser reacts to.
   localparam logic [7:0] CHAR_END       = 8'h00;
   localparam logic [7:0] CHAR_OPEN      = 8'h7B;  // '{'
   localparam logic [7:0] CHAR_CLOSE     = 8'h7D;  // '}'
   localparam logic [7:0] CHAR_LEFT      = 8'h4C;  // 'L'
   localparam logic [7:0] CHAR_RIGHT     = 8'h52;  // 'R'
   localparam logic [7:0] CHAR_CENTRE    = 8'h43;  // 'C'
   localparam logic [7:0] CHAR_HASH      = 8'h23;  // '#'

   // Alignment codes.
   localparam logic [1:0] ALIGN_CENTRE   = 2'd0;
   localparam logic [1:0] ALIGN_LEFT     = 2'd1;
   localparam logic [1:0] ALIGN_RIGHT    = 2'd2;

   // Tag storage and length limits.
   localparam int unsigned TAG_DEPTH     = 9;
   localparam logic [3:0]  COLOUR_TAG_LEN = 4'd9;
   localparam logic [3:0]  TAG_LEN_MAX   = 4'd15;
   localparam logic [7:0]  COLOUR_RESET  = 8'h80;

   // Result field widths and padded data width.
   localparam int unsigned RSP_FIELD_BITS = 34;
   localparam int unsigned RSP_DATA_BITS  = 40;

   typedef logic [TAG_DEPTH-1:0][7:0] tag_text_type;
   typedef logic [3:0][7:0]           colour_set_type;

   // Action decided when a tag closes.
   typedef struct packed {
      logic           set_align;
      logic [1:0]     align;
      logic           set_colour;
      colour_set_type colours;
   } tag_action_type;

   // Hex digit value; anything that is not a digit reads as all ones (-1).
   function automatic logic [7:0] hex_value(input logic [7:0] ch);
      logic [7:0] value;
      if (ch >= 8'h30 && ch <= 8'h39) begin
         value = ch - 8'h30;
      end else if (ch >= 8'h41 && ch <= 8'h46) begin
         value = ch - 8'h37;
      end else if (ch >= 8'h61 && ch <= 8'h66) begin
         value = ch - 8'h57;
      end else begin
         value = 8'hFF;
      end
      return value;
   endfunction

endpackage

`default_nettype wire

### hdl/tstp_tag_decode.sv
// ---------------------------------------------------------------------------
// Tag decoder
// Works out what a closing tag does from its collected text and length.
// ---------------------------------------------------------------------------
`default_nettype none

module tstp_tag_decode
   import tstp_pkg::*;
(
   input  tag_text_type   tag_text,
   input  logic [3:0]     tag_length,
   output tag_action_type action
);

   // Colour bytes: high digit times 16 plus low digit, modulo 256.
   colour_set_type colours;
   colour_set_type hi_digits;
   colour_set_type lo_digits;
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         hi_digits[k] = hex_value(tag_text[1 + 2 * k]);
         lo_digits[k] = hex_value(tag_text[2 + 2 * k]);
         colours[k]   = {hi_digits[k][3:0], 4'h0} + lo_digits[k];
      end
   end

   // The first character selects the action; an empty tag does nothing.
   always_comb begin
      action            = '0;
      action.colours    = colours;
      if (tag_length != 4'd0) begin
         priority if (tag_text[0] == CHAR_LEFT) begin
            action.set_align = 1'b1;
            action.align     = ALIGN_LEFT;
         end else if (tag_text[0] == CHAR_RIGHT) begin
            action.set_align = 1'b1;
            action.align     = ALIGN_RIGHT;
         end else if (tag_text[0] == CHAR_CENTRE) begin
            action.set_align = 1'b1;
            action.align     = ALIGN_CENTRE;
         end else if (tag_text[0] == CHAR_HASH && tag_length == COLOUR_TAG_LEN) begin
            action.set_colour = 1'b1;
         end else begin
            action.set_align = 1'b0;
         end
      end
   end

endmodule

`default_nettype wire

### hdl/text_style_tag_parser.sv
// ---------------------------------------------------------------------------
// Text style tag parser
// Reads text one character per item and applies alignment and colour tags.
// ---------------------------------------------------------------------------
// Usage:
//   The req channel carries one text character per item. Characters inside
//   braces form a tag; on the closing brace an L, R or C tag sets the
//   alignment and a '#' tag with eight hex digits sets the four colour bytes.
//   A zero character ends the string and produces one rsp item holding the
//   current alignment and colours; every other character produces nothing.
//   Alignment and colours carry over from one string to the next.
// Timing:
//   One character is accepted per cycle unless stalled. State is updated in
//   the cycle of acceptance, and the result item is on rsp in the cycle after
//   its zero character is accepted, held in a single output register.
// Stall:
//   req_tready stays high while the output register is empty or is being
//   taken in the same cycle, so a stalled receiver only blocks new input
//   once a result waits in the output register.
// Reset:
//   Closes any open tag, sets centre alignment and all colour bytes to 0x80,
//   and empties the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module text_style_tag_parser
   import tstp_pkg::*;
(
   input  wire  logic                     clock,
   input  wire  logic                     reset,
   // req_tdata: [7:0] char_code
   input  wire  logic [7:0]               req_tdata,
   input  wire  logic                     req_tvalid,
   output logic                           req_tready,
   // rsp_tdata: [1:0] alignment, [9:2] colour_first, [17:10] colour_second,
   //            [25:18] colour_third, [33:26] colour_fourth, [39:34] zero
   output logic [RSP_DATA_BITS-1:0]       rsp_tdata,
   output logic                           rsp_tvalid,
   input  wire  logic                     rsp_tready
);

   logic           tag_open_ff, tag_open_in;
   logic [3:0]     tag_length_ff, tag_length_in;
   tag_text_type   tag_text_ff;
   logic [1:0]     align_ff, align_in;
   colour_set_type colour_ff, colour_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff;
   tag_action_type action;
   logic           accept;
   logic           is_end, is_open, is_close, collect;

   // Accept while the output register is free or drains this cycle.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign is_end   = (req_tdata == CHAR_END);
   assign is_open  = (req_tdata == CHAR_OPEN);
   assign is_close = (req_tdata == CHAR_CLOSE);
   assign collect  = !is_end && !is_open && !is_close && tag_open_ff;

   tstp_tag_decode u_tag_decode (
      .tag_text   (tag_text_ff),
      .tag_length (tag_length_ff),
      .action     (action)
   );

   // Next tag, alignment and colour state for the accepted character.
   always_comb begin
      tag_open_in   = tag_open_ff;
      tag_length_in = tag_length_ff;
      align_in      = align_ff;
      colour_in     = colour_ff;
      if (accept) begin
         priority if (is_end) begin
            tag_open_in   = 1'b0;
            tag_length_in = 4'd0;
         end else if (is_open) begin
            tag_open_in   = 1'b1;
            tag_length_in = 4'd0;
         end else if (is_close) begin
            if (tag_open_ff) begin
               tag_open_in   = 1'b0;
               tag_length_in = 4'd0;
               if (action.set_align) begin
                  align_in = action.align;
               end
               if (action.set_colour) begin
                  colour_in = action.colours;
               end
            end
         end else if (tag_open_ff && tag_length_ff != TAG_LEN_MAX) begin
            tag_length_in = tag_length_ff + 4'd1;
         end else begin
            tag_length_in = tag_length_ff;
         end
      end
   end

   // Output register: loads on an end character, clears when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (accept && is_end) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Control and style state.
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_open_ff   <= 1'b0;
         tag_length_ff <= 4'd0;
         align_ff      <= ALIGN_CENTRE;
         colour_ff     <= {4{COLOUR_RESET}};
         rsp_valid_ff  <= 1'b0;
      end else begin
         tag_open_ff   <= tag_open_in;
         tag_length_ff <= tag_length_in;
         align_ff      <= align_in;
         colour_ff     <= colour_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Tag text: only the first nine characters of a tag are kept.
   always_ff @(posedge clock) begin
      if (accept && collect && tag_length_ff < COLOUR_TAG_LEN) begin
         tag_text_ff[tag_length_ff] <= req_tdata;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (accept && is_end) begin
         rsp_data_ff <= {{(RSP_DATA_BITS - RSP_FIELD_BITS){1'b0}},
                         colour_ff[3], colour_ff[2], colour_ff[1], colour_ff[0],
                         align_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   // An accepted end character always leaves a result waiting.
   a_end_gives_result: assert property (@(posedge clock) disable iff (reset)
      (accept && is_end) |=> rsp_valid_ff)
      else $error("end character did not produce a result");

   // An opening brace starts an empty tag.
   a_open_restarts: assert property (@(posedge clock) disable iff (reset)
      (accept && is_open) |=> (tag_open_ff && tag_length_ff == 4'd0))
      else $error("opening brace did not restart the tag");

   // An end character discards any open tag.
   a_end_closes: assert property (@(posedge clock) disable iff (reset)
      (accept && is_end) |=> (!tag_open_ff && tag_length_ff == 4'd0))
      else $error("end character left a tag open");

   // A closed tag never counts characters.
   a_closed_empty: assert property (@(posedge clock) disable iff (reset)
      !tag_open_ff |-> (tag_length_ff == 4'd0))
      else $error("tag length nonzero while no tag is open");
`endif

endmodule

`default_nettype wire
